>>> rtl/pixel_window_palette_map_defines.svh
// Assertion macros shared by the checker.
`ifndef PIXEL_WINDOW_PALETTE_MAP_DEFINES_SVH
`define PIXEL_WINDOW_PALETTE_MAP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define PWPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pwpm: same-cycle check failed");

// Check cons in the cycle after ante.
`define PWPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pwpm: next-cycle check failed");

`endif

>>> rtl/pwpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwpm_pkg;

  localparam int PALETTE_DEPTH_DEF = 65536;

  localparam int SAMPLE_W = 17;
  localparam int THRESH_W = 18;
  localparam int SCALE_W  = 32;
  localparam int GAIN_W   = 24;
  localparam int DIFF_W   = 19;
  localparam int PROD_W   = DIFF_W + SCALE_W;
  localparam int COLOR_W  = 8;
  localparam int ENTRY_W  = 3 * COLOR_W;
  localparam int INDEX_W  = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_CH     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_THRESHOLD_CH0 = 3'd1,
    REG_THRESHOLD_CH1 = 3'd2,
    REG_THRESHOLD_CH2 = 3'd3,
    REG_SCALE_CH0     = 3'd4,
    REG_SCALE_CH1     = 3'd5,
    REG_SCALE_CH2     = 3'd6,
    REG_CONTROL       = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] CH_COUNT_ONE   = 2'd1;
  localparam logic [1:0] CH_COUNT_TWO   = 2'd2;
  localparam logic [1:0] CH_COUNT_THREE = 2'd3;

  localparam int CTRL_GAIN_BIT  = 0;
  localparam int CTRL_PLANE_LSB = 1;

  localparam logic [1:0]          RST_CHANNEL_COUNT = CH_COUNT_ONE;
  localparam logic [THRESH_W-1:0] RST_THRESHOLD     = '0;
  localparam logic [SCALE_W-1:0]  RST_SCALE         = 32'h0001_0000;
  localparam logic [3:0]          RST_CONTROL       = 4'd14;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } adv_t;

endpackage

`default_nettype wire

>>> rtl/pixel_window_palette_map.sv
`timescale 1ns / 1ps
`default_nettype none

// Window/level palette lookup. Each pixel transfer yields one RGB result; one
// item is taken every clock while out_ready stays high, and a stalled output
// backs the pipeline up only as far as it has no bubbles. The pipeline is
// threshold subtract, Q16.16 scale multiply, gain multiply, clamp/mask,
// palette read and output register. The palette is held as three copies, one
// per channel, each with one read and one write port, so all three lookups
// happen in the same cycle. A palette write (mode 1) takes one pipeline slot
// and gives no result; it is visible to every pixel that follows it. Entries
// that were never written read back undefined. Write configuration only while
// the block is idle; cfg_ready is always high.

module pixel_window_palette_map #(
  parameter int PALETTE_DEPTH = pwpm_pkg::PALETTE_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic                                   in_mode,
  input  wire logic signed [pwpm_pkg::SAMPLE_W-1:0]   in_sample_ch0,
  input  wire logic signed [pwpm_pkg::SAMPLE_W-1:0]   in_sample_ch1,
  input  wire logic signed [pwpm_pkg::SAMPLE_W-1:0]   in_sample_ch2,
  input  wire logic        [pwpm_pkg::GAIN_W-1:0]     in_gain_ch0,
  input  wire logic        [pwpm_pkg::GAIN_W-1:0]     in_gain_ch1,
  input  wire logic        [pwpm_pkg::GAIN_W-1:0]     in_gain_ch2,
  input  wire logic                                   in_mask_bit,
  input  wire logic        [pwpm_pkg::INDEX_W-1:0]    in_entry_index,
  input  wire logic        [pwpm_pkg::COLOR_W-1:0]    in_entry_red,
  input  wire logic        [pwpm_pkg::COLOR_W-1:0]    in_entry_green,
  input  wire logic        [pwpm_pkg::COLOR_W-1:0]    in_entry_blue,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic             [pwpm_pkg::COLOR_W-1:0]    out_red,
  output logic             [pwpm_pkg::COLOR_W-1:0]    out_green,
  output logic             [pwpm_pkg::COLOR_W-1:0]    out_blue,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic        [pwpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [pwpm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(PALETTE_DEPTH);
  localparam int CW = pwpm_pkg::COLOR_W;
  localparam int NC = pwpm_pkg::NUM_CH;

  typedef struct packed {
    logic                           mode;
    logic                           mask;
    logic [pwpm_pkg::INDEX_W-1:0]   addr;
    logic [pwpm_pkg::ENTRY_W-1:0]   rgb;
  } side_t;

  logic [1:0]                            count_r;
  logic signed [pwpm_pkg::THRESH_W-1:0]  thr_r   [NC];
  logic signed [pwpm_pkg::SCALE_W-1:0]   scale_r [NC];
  logic [3:0]                            control_r;

  side_t side_r [1:4];
  logic  [4:1] vld_r;
  logic        vld5_r;
  logic        out_valid_r;
  logic [CW-1:0] out_red_r, out_green_r, out_blue_r;
  logic [CW-1:0] red_nxt, green_nxt, blue_nxt;

  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  pwpm_pkg::adv_t adv;

  logic signed [pwpm_pkg::SAMPLE_W-1:0] samp [NC];
  logic        [pwpm_pkg::GAIN_W-1:0]   gain [NC];
  logic        [AW-1:0]                 idx  [NC];
  logic        [pwpm_pkg::ENTRY_W-1:0]  pal_q [NC];
  logic                                 wr_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= pwpm_pkg::RST_CHANNEL_COUNT;
      control_r <= pwpm_pkg::RST_CONTROL;
      for (int c = 0; c < NC; c++) begin
        thr_r[c]   <= pwpm_pkg::RST_THRESHOLD;
        scale_r[c] <= pwpm_pkg::RST_SCALE;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (pwpm_pkg::cfg_reg_t'(cfg_index))
        pwpm_pkg::REG_CHANNEL_COUNT: count_r    <= cfg_data[1:0];
        pwpm_pkg::REG_THRESHOLD_CH0: thr_r[0]   <= cfg_data[pwpm_pkg::THRESH_W-1:0];
        pwpm_pkg::REG_THRESHOLD_CH1: thr_r[1]   <= cfg_data[pwpm_pkg::THRESH_W-1:0];
        pwpm_pkg::REG_THRESHOLD_CH2: thr_r[2]   <= cfg_data[pwpm_pkg::THRESH_W-1:0];
        pwpm_pkg::REG_SCALE_CH0:     scale_r[0] <= cfg_data[pwpm_pkg::SCALE_W-1:0];
        pwpm_pkg::REG_SCALE_CH1:     scale_r[1] <= cfg_data[pwpm_pkg::SCALE_W-1:0];
        pwpm_pkg::REG_SCALE_CH2:     scale_r[2] <= cfg_data[pwpm_pkg::SCALE_W-1:0];
        pwpm_pkg::REG_CONTROL:       control_r  <= cfg_data[3:0];
      endcase
    end
  end

  // a stage advances when it is empty or the stage after it advances
  assign rdy6     = !out_valid_r || out_ready;
  assign rdy5     = !vld5_r || rdy6;
  assign rdy4     = !vld_r[4] || rdy5;
  assign rdy3     = !vld_r[3] || rdy4;
  assign rdy2     = !vld_r[2] || rdy3;
  assign rdy1     = !vld_r[1] || rdy2;
  assign in_ready = rdy1;

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;
  assign adv.s4 = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      vld5_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) vld_r[1] <= in_valid;
      if (rdy2) vld_r[2] <= vld_r[1];
      if (rdy3) vld_r[3] <= vld_r[2];
      if (rdy4) vld_r[4] <= vld_r[3];
      // drop palette writes here: they give no result
      if (rdy5) vld5_r <= vld_r[4] && !side_r[4].mode;
      if (rdy6) out_valid_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      side_r[1] <= '{mode: in_mode, mask: in_mask_bit, addr: in_entry_index,
                     rgb: {in_entry_red, in_entry_green, in_entry_blue}};
    end
    if (rdy2) side_r[2] <= side_r[1];
    if (rdy3) side_r[3] <= side_r[2];
    if (rdy4) side_r[4] <= side_r[3];
  end

  assign samp[0] = in_sample_ch0;
  assign samp[1] = in_sample_ch1;
  assign samp[2] = in_sample_ch2;
  assign gain[0] = in_gain_ch0;
  assign gain[1] = in_gain_ch1;
  assign gain[2] = in_gain_ch2;

  assign wr_en = rdy5 && vld_r[4] && side_r[4].mode &&
                 ((pwpm_pkg::INDEX_W + 1)'(side_r[4].addr) <
                  (pwpm_pkg::INDEX_W + 1)'(PALETTE_DEPTH));

  for (genvar c = 0; c < NC; c++) begin : g_ch
    pwpm_chan #(
      .DEPTH     (PALETTE_DEPTH)
    ) u_chan (
      .clk       (clk),
      .adv       (adv),
      .sample    (samp[c]),
      .gain      (gain[c]),
      .threshold (thr_r[c]),
      .scale     (scale_r[c]),
      .gain_en   (control_r[pwpm_pkg::CTRL_GAIN_BIT]),
      .plane_en  (control_r[pwpm_pkg::CTRL_PLANE_LSB + c]),
      .mask_s3   (side_r[3].mask),
      .idx       (idx[c])
    );

    pwpm_palette #(
      .DEPTH   (PALETTE_DEPTH)
    ) u_palette (
      .clk     (clk),
      .wr_en   (wr_en),
      .wr_addr (side_r[4].addr[AW-1:0]),
      .wr_data (side_r[4].rgb),
      .rd_en   (rdy5),
      .rd_addr (idx[c]),
      .rd_data (pal_q[c])
    );
  end

  always_comb begin
    blue_nxt = pal_q[0][CW-1:0];
    unique case (count_r)
      pwpm_pkg::CH_COUNT_TWO: begin
        red_nxt   = pal_q[1][3*CW-1:2*CW];
        green_nxt = pal_q[1][2*CW-1:CW];
      end
      pwpm_pkg::CH_COUNT_THREE: begin
        red_nxt   = pal_q[2][3*CW-1:2*CW];
        green_nxt = pal_q[1][2*CW-1:CW];
      end
      default: begin
        red_nxt   = pal_q[0][3*CW-1:2*CW];
        green_nxt = pal_q[0][2*CW-1:CW];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      out_red_r   <= red_nxt;
      out_green_r <= green_nxt;
      out_blue_r  <= blue_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

`default_nettype wire

>>> rtl/pwpm_palette.sv
`timescale 1ns / 1ps
`default_nettype none

module pwpm_palette #(
  parameter int DEPTH = pwpm_pkg::PALETTE_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic                         clk,
  input  wire logic                         wr_en,
  input  wire logic [AW-1:0]                wr_addr,
  input  wire logic [pwpm_pkg::ENTRY_W-1:0] wr_data,
  input  wire logic                         rd_en,
  input  wire logic [AW-1:0]                rd_addr,
  output logic      [pwpm_pkg::ENTRY_W-1:0] rd_data
);

  logic [pwpm_pkg::ENTRY_W-1:0] mem_r [DEPTH];
  logic [pwpm_pkg::ENTRY_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> rtl/pwpm_chan.sv
`timescale 1ns / 1ps
`default_nettype none

module pwpm_chan #(
  parameter int DEPTH = pwpm_pkg::PALETTE_DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic                                 clk,
  input  wire pwpm_pkg::adv_t                       adv,
  input  wire logic signed [pwpm_pkg::SAMPLE_W-1:0] sample,
  input  wire logic        [pwpm_pkg::GAIN_W-1:0]   gain,
  input  wire logic signed [pwpm_pkg::THRESH_W-1:0] threshold,
  input  wire logic signed [pwpm_pkg::SCALE_W-1:0]  scale,
  input  wire logic                                 gain_en,
  input  wire logic                                 plane_en,
  input  wire logic                                 mask_s3,
  output logic             [AW-1:0]                 idx
);

  localparam int DW    = pwpm_pkg::DIFF_W;
  localparam int PW    = pwpm_pkg::PROD_W;
  localparam int GW    = pwpm_pkg::GAIN_W;
  localparam int VHI_W = PW - 1 - 16;
  localparam int HI_W  = VHI_W + GW;
  localparam int LO_W  = 16 + GW;
  localparam int Q_W   = HI_W - 16;

  logic signed [DW-1:0]    diff_r, diff_nxt;
  logic        [GW-1:0]    gain1_r, gain2_r;
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic                    pos_r, pos_nxt;
  logic        [HI_W-1:0]  hi_r, hi_nxt;
  logic        [GW-1:0]    lo_r, lo_nxt;
  logic        [VHI_W-1:0] plain_r;
  logic        [LO_W-1:0]  lo_prod;
  logic        [HI_W-1:0]  sum;
  logic        [Q_W-1:0]   val;
  logic        [AW-1:0]    clamp;
  logic        [AW-1:0]    idx_r, idx_nxt;

  always_comb begin
    diff_nxt = DW'(sample) - DW'(threshold);
    prod_nxt = PW'(diff_r) * PW'(scale);
    pos_nxt  = !prod_r[PW-1] && (|prod_r);
    hi_nxt   = HI_W'(prod_r[PW-2:16]) * HI_W'(gain2_r);
    lo_prod  = LO_W'(prod_r[15:0]) * LO_W'(gain2_r);
    lo_nxt   = lo_prod[LO_W-1:16];
  end

  always_comb begin
    sum = hi_r + HI_W'(lo_r);
    val = gain_en ? sum[HI_W-1:16] : Q_W'(plain_r);
    if (val >= Q_W'(DEPTH)) begin
      clamp = AW'(DEPTH - 1);
    end else begin
      clamp = val[AW-1:0];
    end
    idx_nxt = mask_s3 ? clamp : (clamp >> 1);
    if (!plane_en || !pos_r) begin
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      diff_r  <= diff_nxt;
      gain1_r <= gain;
    end
    if (adv.s2) begin
      prod_r  <= prod_nxt;
      gain2_r <= gain1_r;
    end
    if (adv.s3) begin
      pos_r   <= pos_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
      plain_r <= prod_r[PW-2:16];
    end
    if (adv.s4) begin
      idx_r <= idx_nxt;
    end
  end

  assign idx = idx_r;

endmodule

`default_nettype wire

>>> rtl/pwpm_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "pixel_window_palette_map_defines.svh"

module pwpm_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [pwpm_pkg::COLOR_W-1:0]      out_red,
  input wire logic [pwpm_pkg::COLOR_W-1:0]      out_green,
  input wire logic [pwpm_pkg::COLOR_W-1:0]      out_blue,
  input wire logic                              cfg_ready
);

  logic [pwpm_pkg::ENTRY_W-1:0] out_rgb;

  assign out_rgb = {out_red, out_green, out_blue};

  // hold a stalled result
  `PWPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_rgb))

  // no result right out of reset
  `PWPM_ASSERT_IMPL(a_rst_empty, clk, rst_n, $rose(rst_n), !out_valid)

  // an open output stage lets every stage advance
  `PWPM_ASSERT_IMPL(a_in_open, clk, rst_n, !out_valid || out_ready, in_ready && cfg_ready)

endmodule

bind pixel_window_palette_map pwpm_checker u_pwpm_checker (.*);

`default_nettype wire

>>> tb/palette_map_check.sv
`timescale 1ns / 1ps

module palette_map_check (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic                                   in_ready,
  input  logic                                   in_mode,
  input  logic        [pwpm_pkg::SAMPLE_W-1:0]   in_sample_ch0,
  input  logic        [pwpm_pkg::SAMPLE_W-1:0]   in_sample_ch1,
  input  logic        [pwpm_pkg::SAMPLE_W-1:0]   in_sample_ch2,
  input  logic        [pwpm_pkg::GAIN_W-1:0]     in_gain_ch0,
  input  logic        [pwpm_pkg::GAIN_W-1:0]     in_gain_ch1,
  input  logic        [pwpm_pkg::GAIN_W-1:0]     in_gain_ch2,
  input  logic                                   in_mask_bit,
  input  logic        [pwpm_pkg::INDEX_W-1:0]    in_entry_index,
  input  logic        [pwpm_pkg::COLOR_W-1:0]    in_entry_red,
  input  logic        [pwpm_pkg::COLOR_W-1:0]    in_entry_green,
  input  logic        [pwpm_pkg::COLOR_W-1:0]    in_entry_blue,
  input  logic                                   out_valid,
  input  logic                                   out_ready,
  input  logic        [pwpm_pkg::COLOR_W-1:0]    out_red,
  input  logic        [pwpm_pkg::COLOR_W-1:0]    out_green,
  input  logic        [pwpm_pkg::COLOR_W-1:0]    out_blue,
  input  logic                                   cfg_valid,
  input  logic                                   cfg_ready,
  input  logic        [pwpm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [pwpm_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                     mismatch_count,
  output int                                     colors_pending
);

  localparam int SW = pwpm_pkg::SAMPLE_W;
  localparam int GW = pwpm_pkg::GAIN_W;
  localparam int TW = pwpm_pkg::THRESH_W;
  localparam int KW = pwpm_pkg::SCALE_W;
  localparam int DW = pwpm_pkg::DIFF_W;
  localparam int PW = pwpm_pkg::PROD_W;
  localparam int IW = pwpm_pkg::INDEX_W;
  localparam int CW = pwpm_pkg::COLOR_W;
  localparam int NCH = pwpm_pkg::NUM_CH;
  localparam int SCALE_FRAC = 16;
  localparam int GAIN_FRAC = 16;
  localparam logic [IW-1:0] LAST_SLOT = IW'(pwpm_pkg::PALETTE_DEPTH_DEF - 1);

  typedef struct packed {
    logic [CW-1:0] red;
    logic [CW-1:0] green;
    logic [CW-1:0] blue;
  } rgb_t;

  rgb_t                 palette_copy [pwpm_pkg::PALETTE_DEPTH_DEF];
  logic [1:0]           channel_count;
  logic signed [TW-1:0] threshold [NCH];
  logic signed [KW-1:0] scale [NCH];
  logic [3:0]           control;
  rgb_t                 pending_colors [$];
  int                   errors = 0;

  function automatic logic [IW-1:0] lookup_slot(input int ch,
                                                input logic signed [SW-1:0] sample,
                                                input logic [GW-1:0] gain,
                                                input logic mask_bit);
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic [PW+GW-1:0]     gained;
    logic [PW-1:0]        level;
    logic [IW-1:0]        slot;
    diff = sample - threshold[ch];
    prod = diff * scale[ch];
    gained = prod[PW-2:0] * gain;
    if (prod <= 0) begin
      level = '0;
    end else if (control[pwpm_pkg::CTRL_GAIN_BIT]) begin
      level = PW'(gained >> (SCALE_FRAC + GAIN_FRAC));
    end else begin
      level = $unsigned(prod) >> SCALE_FRAC;
    end
    if (level > LAST_SLOT) slot = LAST_SLOT;
    else slot = level[IW-1:0];
    if (!mask_bit) slot = slot >> 1;
    if (!control[pwpm_pkg::CTRL_PLANE_LSB + ch]) slot = '0;
    return slot;
  endfunction

  function automatic rgb_t predict_color(input logic [NCH-1:0][SW-1:0] samples,
                                         input logic [NCH-1:0][GW-1:0] gains,
                                         input logic mask_bit);
    rgb_t e [NCH];
    rgb_t c;
    int   used;
    used = (channel_count == pwpm_pkg::CH_COUNT_THREE) ? 3 :
           (channel_count == pwpm_pkg::CH_COUNT_TWO)   ? 2 : 1;
    for (int ch = 0; ch < NCH; ch++) begin
      e[ch] = (ch < used) ? palette_copy[lookup_slot(ch, samples[ch], gains[ch], mask_bit)]
                          : '0;
    end
    case (channel_count)
      pwpm_pkg::CH_COUNT_THREE: begin
        c.red = e[2].red;
        c.green = e[1].green;
      end
      pwpm_pkg::CH_COUNT_TWO: begin
        c.red = e[1].red;
        c.green = e[1].green;
      end
      default: begin
        c.red = e[0].red;
        c.green = e[0].green;
      end
    endcase
    c.blue = e[0].blue;
    return c;
  endfunction

  task automatic check_field(input string name, input logic [CW-1:0] want, got);
    if (got !== want) begin
      errors++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    rgb_t got;
    rgb_t want;
    if (!rst_n) begin
      channel_count = pwpm_pkg::RST_CHANNEL_COUNT;
      control = pwpm_pkg::RST_CONTROL;
      for (int ch = 0; ch < NCH; ch++) begin
        threshold[ch] = pwpm_pkg::RST_THRESHOLD;
        scale[ch] = pwpm_pkg::RST_SCALE;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pwpm_pkg::REG_CHANNEL_COUNT: channel_count = cfg_data[1:0];
          pwpm_pkg::REG_THRESHOLD_CH0: threshold[0] = cfg_data[TW-1:0];
          pwpm_pkg::REG_THRESHOLD_CH1: threshold[1] = cfg_data[TW-1:0];
          pwpm_pkg::REG_THRESHOLD_CH2: threshold[2] = cfg_data[TW-1:0];
          pwpm_pkg::REG_SCALE_CH0:     scale[0] = cfg_data[KW-1:0];
          pwpm_pkg::REG_SCALE_CH1:     scale[1] = cfg_data[KW-1:0];
          pwpm_pkg::REG_SCALE_CH2:     scale[2] = cfg_data[KW-1:0];
          pwpm_pkg::REG_CONTROL:       control = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_mode) begin
          palette_copy[in_entry_index] = {in_entry_red, in_entry_green, in_entry_blue};
        end else begin
          want = predict_color({in_sample_ch2, in_sample_ch1, in_sample_ch0},
                               {in_gain_ch2, in_gain_ch1, in_gain_ch0},
                               in_mask_bit);
          pending_colors = {pending_colors, want};
        end
      end
      if (out_valid && out_ready) begin
        got = {out_red, out_green, out_blue};
        if (pending_colors.size() == 0) begin
          errors++;
          $error("unexpected result transfer: red %0d green %0d blue %0d",
                 got.red, got.green, got.blue);
        end else begin
          want = pending_colors.pop_front();
          check_field("out_red", want.red, got.red);
          check_field("out_green", want.green, got.green);
          check_field("out_blue", want.blue, got.blue);
        end
      end
    end
    mismatch_count <= errors;
    colors_pending <= pending_colors.size();
  end

endmodule

>>> tb/pixel_window_palette_map_tb.sv
`timescale 1ns / 1ps

module pixel_window_palette_map_tb;

  localparam int SW = pwpm_pkg::SAMPLE_W;
  localparam int GW = pwpm_pkg::GAIN_W;
  localparam int TW = pwpm_pkg::THRESH_W;
  localparam int KW = pwpm_pkg::SCALE_W;
  localparam int IW = pwpm_pkg::INDEX_W;
  localparam int CW = pwpm_pkg::COLOR_W;
  localparam int NCH = pwpm_pkg::NUM_CH;

  localparam logic MODE_PIXEL   = 1'b0;
  localparam logic MODE_PALETTE = 1'b1;

  localparam logic [3:0] GAIN_ON    = 4'b0001 << pwpm_pkg::CTRL_GAIN_BIT;
  localparam logic [3:0] PLANE0_ON  = 4'b0001 << pwpm_pkg::CTRL_PLANE_LSB;
  localparam logic [3:0] PLANE1_ON  = 4'b0010 << pwpm_pkg::CTRL_PLANE_LSB;
  localparam logic [3:0] ALL_PLANES = 4'b0111 << pwpm_pkg::CTRL_PLANE_LSB;

  localparam logic [SW-1:0] SAMPLE_MAX = 17'h0FFFF;
  localparam logic [SW-1:0] SAMPLE_MIN = 17'h10000;
  localparam logic [SW-1:0] SAMPLE_NEG1 = 17'h1FFFF;
  localparam logic [TW-1:0] THRESH_MAX = 18'h1FFFF;
  localparam logic [TW-1:0] THRESH_MIN = 18'h20000;
  localparam logic [GW-1:0] GAIN_UNITY = 24'h010000;
  localparam logic [GW-1:0] GAIN_MAX = 24'hFFFFFF;
  localparam logic [KW-1:0] SCALE_MAX = 32'h7FFFFFFF;
  localparam logic [KW-1:0] SCALE_MIN = 32'h80000000;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 205;

  typedef struct packed {
    logic                    mode;
    logic [NCH-1:0][SW-1:0]  sample;
    logic [NCH-1:0][GW-1:0]  gain;
    logic                    mask_bit;
    logic [IW-1:0]           entry_index;
    logic [CW-1:0]           red;
    logic [CW-1:0]           green;
    logic [CW-1:0]           blue;
  } pixel_req_t;

  localparam int REQ_W = $bits(pixel_req_t);

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  logic          in_mode = 1'b0;
  logic [SW-1:0] in_sample_ch0 = '0;
  logic [SW-1:0] in_sample_ch1 = '0;
  logic [SW-1:0] in_sample_ch2 = '0;
  logic [GW-1:0] in_gain_ch0 = '0;
  logic [GW-1:0] in_gain_ch1 = '0;
  logic [GW-1:0] in_gain_ch2 = '0;
  logic          in_mask_bit = 1'b0;
  logic [IW-1:0] in_entry_index = '0;
  logic [CW-1:0] in_entry_red = '0;
  logic [CW-1:0] in_entry_green = '0;
  logic [CW-1:0] in_entry_blue = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [CW-1:0] out_red;
  logic [CW-1:0] out_green;
  logic [CW-1:0] out_blue;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [pwpm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pwpm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned          cycle_count = 0;
  bit                   calm = 1'b0;
  logic signed [TW-1:0] cur_thr [NCH] = '{default: '0};
  int                   fails;
  int                   pending;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  pixel_window_palette_map dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_sample_ch0  (in_sample_ch0),
    .in_sample_ch1  (in_sample_ch1),
    .in_sample_ch2  (in_sample_ch2),
    .in_gain_ch0    (in_gain_ch0),
    .in_gain_ch1    (in_gain_ch1),
    .in_gain_ch2    (in_gain_ch2),
    .in_mask_bit    (in_mask_bit),
    .in_entry_index (in_entry_index),
    .in_entry_red   (in_entry_red),
    .in_entry_green (in_entry_green),
    .in_entry_blue  (in_entry_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  palette_map_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_sample_ch0  (in_sample_ch0),
    .in_sample_ch1  (in_sample_ch1),
    .in_sample_ch2  (in_sample_ch2),
    .in_gain_ch0    (in_gain_ch0),
    .in_gain_ch1    (in_gain_ch1),
    .in_gain_ch2    (in_gain_ch2),
    .in_mask_bit    (in_mask_bit),
    .in_entry_index (in_entry_index),
    .in_entry_red   (in_entry_red),
    .in_entry_green (in_entry_green),
    .in_entry_blue  (in_entry_blue),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (fails),
    .colors_pending (pending)
  );

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [SW-1:0] pick_sample(input int ch);
    int roll;
    int v;
    roll = $urandom_range(99);
    if (roll < 8) return ($urandom_range(1) != 0) ? SAMPLE_MAX : SAMPLE_MIN;
    if (roll < 35) return SW'($urandom);
    if (roll < 75) v = int'(cur_thr[ch]) + int'($urandom_range(4200)) - 200;
    else v = int'(cur_thr[ch]) + int'($urandom_range(70000)) - 200;
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return SW'(v);
  endfunction

  function automatic logic [GW-1:0] pick_gain();
    int roll;
    roll = $urandom_range(99);
    if (roll < 4) return '0;
    if (roll < 7) return GAIN_MAX;
    if (roll < 10) return GAIN_UNITY;
    if (roll < 50) return GW'(int'(GAIN_UNITY) + int'($urandom_range(16384)) - 8192);
    if (roll < 70) return GW'($urandom_range(65535));
    return GW'($urandom);
  endfunction

  function automatic logic [TW-1:0] pick_threshold();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return THRESH_MAX;
    if (roll < 15) return THRESH_MIN;
    if (roll < 35) return TW'($urandom);
    return TW'(int'($urandom_range(140000)) - 70000);
  endfunction

  function automatic logic [KW-1:0] pick_scale();
    int roll;
    int mag;
    roll = $urandom_range(99);
    if (roll < 4) return SCALE_MAX;
    if (roll < 8) return SCALE_MIN;
    if (roll < 11) return '0;
    if (roll < 15) return '1;
    if (roll < 30) return $urandom;
    mag = $urandom_range(4096, 262144);
    return ($urandom_range(3) == 0) ? KW'(-mag) : KW'(mag);
  endfunction

  function automatic logic [1:0] pick_count();
    if ($urandom_range(9) == 0) return '0;
    return 2'($urandom_range(1, 3));
  endfunction

  function automatic logic [3:0] pick_control();
    logic [3:0] c;
    c = 4'($urandom);
    if ($urandom_range(3) != 0) c = c | ALL_PLANES;
    return c;
  endfunction

  task automatic send_item(input pixel_req_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= it.mode;
    in_sample_ch0 <= it.sample[0];
    in_sample_ch1 <= it.sample[1];
    in_sample_ch2 <= it.sample[2];
    in_gain_ch0 <= it.gain[0];
    in_gain_ch1 <= it.gain[1];
    in_gain_ch2 <= it.gain[2];
    in_mask_bit <= it.mask_bit;
    in_entry_index <= it.entry_index;
    in_entry_red <= it.red;
    in_entry_green <= it.green;
    in_entry_blue <= it.blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_pixel(input logic [SW-1:0] s0, s1, s2,
                            input logic [GW-1:0] g0, g1, g2,
                            input logic mask_bit);
    pixel_req_t it;
    it = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.mode = MODE_PIXEL;
    it.sample = {s2, s1, s0};
    it.gain = {g2, g1, g0};
    it.mask_bit = mask_bit;
    send_item(it);
  endtask

  task automatic send_entry(input logic [IW-1:0] slot, input logic [CW-1:0] r, g, b);
    pixel_req_t it;
    it = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    it.mode = MODE_PALETTE;
    it.entry_index = slot;
    it.red = r;
    it.green = g;
    it.blue = b;
    send_item(it);
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input pwpm_pkg::cfg_reg_t r, input logic [31:0] value,
                           input int width);
    logic [31:0] keep;
    keep = (width >= 32) ? '1 : ((32'd1 << width) - 32'd1);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= ($urandom & ~keep) | (value & keep);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [1:0] count,
                               input logic [TW-1:0] t0, t1, t2,
                               input logic [KW-1:0] k0, k1, k2,
                               input logic [3:0] ctrl);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(pwpm_pkg::REG_CHANNEL_COUNT, 32'(count), 2);
    write_reg(pwpm_pkg::REG_THRESHOLD_CH0, 32'(t0), TW);
    write_reg(pwpm_pkg::REG_THRESHOLD_CH1, 32'(t1), TW);
    write_reg(pwpm_pkg::REG_THRESHOLD_CH2, 32'(t2), TW);
    write_reg(pwpm_pkg::REG_SCALE_CH0, k0, KW);
    write_reg(pwpm_pkg::REG_SCALE_CH1, k1, KW);
    write_reg(pwpm_pkg::REG_SCALE_CH2, k2, KW);
    write_reg(pwpm_pkg::REG_CONTROL, 32'(ctrl), 4);
    cfg_valid <= 1'b0;
    cur_thr[0] = t0;
    cur_thr[1] = t1;
    cur_thr[2] = t2;
    @(posedge clk);
  endtask

  task automatic run_random_phase(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(9) == 0) begin
        send_entry(IW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
      end else begin
        send_pixel(pick_sample(0), pick_sample(1), pick_sample(2),
                   pick_gain(), pick_gain(), pick_gain(), $urandom_range(3) != 0);
      end
    end
  endtask

  initial begin : result_side
    int stall;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall == 0) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  initial begin : timeout
    wait (cycle_count >= CYCLE_LIMIT);
    $display("pixel_window_palette_map_tb: FAIL");
    $finish;
  end

  initial begin : stimulus
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every palette entry so no lookup can hit an unwritten one
    calm = 1'b1;
    for (int i = 0; i < pwpm_pkg::PALETTE_DEPTH_DEF; i++) begin
      send_entry(IW'(i), CW'($urandom), CW'($urandom), CW'($urandom));
    end
    calm = 1'b0;

    send_pixel('0, SW'($urandom), SW'($urandom), GAIN_MAX, GW'($urandom), GW'($urandom), 1'b1);
    send_pixel(SAMPLE_MAX, SW'($urandom), SW'($urandom), '0, '0, '0, 1'b1);
    send_pixel(SAMPLE_MAX, SW'($urandom), SW'($urandom), '0, '0, '0, 1'b0);
    send_pixel(SAMPLE_MIN, SW'($urandom), SW'($urandom), GAIN_UNITY, '0, '0, 1'b1);
    send_pixel(17'd1234, SW'($urandom), SW'($urandom), GAIN_UNITY, '0, '0, 1'b1);
    send_entry(16'd1234, 8'hA5, 8'h5A, 8'hC3);
    send_pixel(17'd1234, SW'($urandom), SW'($urandom), GAIN_UNITY, '0, '0, 1'b1);
    send_entry(16'hFFFF, 8'hFF, 8'h00, 8'hFF);
    send_pixel(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b1);

    apply_setting(pwpm_pkg::CH_COUNT_THREE, THRESH_MIN, THRESH_MAX, '0,
                  SCALE_MAX, SCALE_MIN, pwpm_pkg::RST_SCALE, GAIN_ON | ALL_PLANES);
    send_pixel(SAMPLE_MAX, SAMPLE_MIN, 17'd300, GAIN_MAX, '0, GAIN_UNITY, 1'b1);
    send_pixel(SAMPLE_MAX, SAMPLE_MIN, 17'd300, GAIN_MAX, GAIN_MAX, GAIN_UNITY, 1'b0);
    send_pixel(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_NEG1, '0, GAIN_MAX, 24'h008000, 1'b1);

    apply_setting(pwpm_pkg::CH_COUNT_TWO, '0, '0, '0, pwpm_pkg::RST_SCALE,
                  pwpm_pkg::RST_SCALE, pwpm_pkg::RST_SCALE, '0);
    send_pixel(17'd500, 17'd700, 17'd900, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, 1'b1);
    send_pixel(SAMPLE_NEG1, SAMPLE_MAX, '0, GAIN_MAX, '0, GAIN_MAX, 1'b0);

    apply_setting('0, 18'd100, 18'd100, 18'd100, 32'h0001_8000, 32'h0001_8000,
                  32'h0001_8000, GAIN_ON | PLANE0_ON);
    send_pixel(17'd1000, SW'($urandom), SW'($urandom), 24'h008000, GW'($urandom),
               GW'($urandom), 1'b1);
    send_pixel(17'd99, SW'($urandom), SW'($urandom), GAIN_MAX, '0, '0, 1'b1);
    send_pixel(SAMPLE_MAX, SW'($urandom), SW'($urandom), 24'h020000, '0, '0, 1'b0);

    apply_setting(pwpm_pkg::CH_COUNT_TWO, -18'sd5, 18'd40000, '0, 32'hFFFF_0000,
                  32'h0002_0000, pwpm_pkg::RST_SCALE, PLANE0_ON | PLANE1_ON);
    send_pixel(-17'sd1000, 17'd41000, SW'($urandom), '0, '0, '0, 1'b1);
    send_pixel(SAMPLE_MAX, SAMPLE_MIN, SW'($urandom), GAIN_MAX, GAIN_MAX, '0, 1'b0);

    for (int ph = 0; ph < PHASES; ph++) begin
      apply_setting(pick_count(), pick_threshold(), pick_threshold(), pick_threshold(),
                    pick_scale(), pick_scale(), pick_scale(), pick_control());
      calm = (ph == 3);
      run_random_phase(PHASE_ITEMS);
      calm = 1'b0;
    end

    in_valid <= 1'b0;
    wait_drained();
    if (fails == 0) begin
      $display("pixel_window_palette_map_tb: PASS");
    end else begin
      $display("pixel_window_palette_map_tb: FAIL");
    end
    $finish;
  end

endmodule
